// ===== rtl/muw_pkg.sv =====
// shared types and constants for the mail text unwrapper
package muw_pkg;

  // quote depth field width, wide enough for the largest supported depth
  localparam int unsigned QD_W = 6;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CNT_TOP  = 8'd255;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_CHAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_FOR_GAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDENT_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIM     = 3'd4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] quote_char;
    logic       tab_for_gaps;
    logic [7:0] indent_limit;
    logic [7:0] short_line_limit;
    logic [7:0] gap_limit;
  } cfg_t;

  // one queued command: optional lead byte, a run of quote bytes, then the main byte
  typedef struct packed {
    logic            pre_v;
    logic [7:0]      pre_c;
    logic [QD_W-1:0] qcnt;
    logic [7:0]      main_c;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } q_status_t;

  typedef enum logic {
    PH_PRE,
    PH_QUOTE
  } ph_e;

endpackage

// ===== rtl/muw_front.sv =====
// front end: classifies each input byte, tracks line state, issues commands
module muw_front #(
  parameter int unsigned MaxQuoteDepth = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  muw_pkg::in_item_t item_i,
  input  muw_pkg::cfg_t    cfg_i,
  output logic             push_o,
  output muw_pkg::cmd_t    cmd_o
);
  import muw_pkg::*;

  localparam logic [QD_W-1:0] QdTop = QD_W'(MaxQuoteDepth);

  logic [7:0]      len_q, len_d;
  logic [7:0]      ind_q, ind_d;
  logic [QD_W-1:0] qd_q, qd_d;
  logic            lkb_q, lkb_d;
  logic [7:0]      pind_q, pind_d;
  logic [QD_W-1:0] pqd_q, pqd_d;
  logic            pkb_q, pkb_d;
  logic            start_q, start_d;
  logic [7:0]      ps_q, ps_d;

  logic            keep;
  logic [QD_W-1:0] qadd;
  logic            add_one;
  logic [8:0]      len_sum;
  logic [7:0]      len1;
  logic [7:0]      len2;
  logic [7:0]      c;

  assign c = item_i.char_in;

  always_comb begin
    len_d   = len_q;
    ind_d   = ind_q;
    qd_d    = qd_q;
    lkb_d   = lkb_q;
    pind_d  = pind_q;
    pqd_d   = pqd_q;
    pkb_d   = pkb_q;
    start_d = start_q;
    ps_d    = ps_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    keep    = 1'b0;
    qadd    = '0;
    add_one = 1'b0;
    len_sum = '0;
    len1    = '0;
    len2    = '0;

    if (accept_i) begin
      priority if (c == CH_LF) begin
        keep = lkb_q || (ind_q > cfg_i.indent_limit) || (len_q < cfg_i.short_line_limit);
        push_o       = 1'b1;
        cmd_o.pre_v  = keep && (len_q == 8'd0) && !pkb_q;
        cmd_o.pre_c  = CH_LF;
        cmd_o.main_c = keep ? CH_LF : CH_SPACE;
        pind_d  = ind_q;
        pqd_d   = qd_q;
        pkb_d   = keep;
        len_d   = '0;
        ind_d   = '0;
        qd_d    = '0;
        lkb_d   = 1'b0;
        start_d = 1'b1;
        ps_d    = '0;
      end else if (c == CH_SPACE) begin
        if (start_q) ind_d = (ind_q == CNT_TOP) ? CNT_TOP : ind_q + 8'd1;
        else         ps_d  = (ps_q == CNT_TOP) ? CNT_TOP : ps_q + 8'd1;
      end else if (start_q && c == cfg_i.quote_char) begin
        qd_d = (qd_q >= QdTop) ? QdTop : qd_q + QD_W'(1);
      end else begin
        push_o       = 1'b1;
        cmd_o.main_c = c;
        if (!start_q) begin
          if (ps_q > cfg_i.gap_limit && cfg_i.tab_for_gaps) begin
            cmd_o.pre_v = 1'b1;
            cmd_o.pre_c = CH_TAB;
            lkb_d       = 1'b1;
          end else if (ps_q != 8'd0) begin
            cmd_o.pre_v = 1'b1;
            cmd_o.pre_c = CH_SPACE;
            add_one     = 1'b1;
          end
        end else if ((ind_q > pind_q || qd_q != pqd_q) && !pkb_q) begin
          cmd_o.pre_v = 1'b1;
          cmd_o.pre_c = CH_LF;
          cmd_o.qcnt  = qd_q;
          qadd        = qd_q;
        end else if (qd_q != '0 && pkb_q) begin
          cmd_o.qcnt = qd_q;
          qadd       = qd_q;
        end
        // quote run (or one space) first, then the byte itself, each saturating
        len_sum = {1'b0, len_q} + {{(9-QD_W){1'b0}}, qadd} + {8'd0, add_one};
        len1    = len_sum[8] ? CNT_TOP : len_sum[7:0];
        len2    = (len1 == CNT_TOP) ? CNT_TOP : len1 + 8'd1;
        len_d   = len2;
        start_d = 1'b0;
        ps_d    = '0;
      end

      if (item_i.end_of_text) begin
        len_d   = '0;
        ind_d   = '0;
        qd_d    = '0;
        lkb_d   = 1'b0;
        pind_d  = '0;
        pqd_d   = '0;
        pkb_d   = 1'b1;
        start_d = 1'b1;
        ps_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ind_q   <= '0;
      qd_q    <= '0;
      lkb_q   <= 1'b0;
      pind_q  <= '0;
      pqd_q   <= '0;
      pkb_q   <= 1'b1;
      start_q <= 1'b1;
      ps_q    <= '0;
    end else begin
      len_q   <= len_d;
      ind_q   <= ind_d;
      qd_q    <= qd_d;
      lkb_q   <= lkb_d;
      pind_q  <= pind_d;
      pqd_q   <= pqd_d;
      pkb_q   <= pkb_d;
      start_q <= start_d;
      ps_q    <= ps_d;
    end
  end

endmodule

// ===== rtl/muw_queue.sv =====
// two-entry command queue between front and back
module muw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  muw_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output logic                head_v_o,
  output muw_pkg::cmd_t       head_o,
  output muw_pkg::q_status_t  status_o
);
  import muw_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign head_v_o        = (cnt_q != 2'd0);
  assign head_o          = mem_q[rd_q];
  assign status_o.full   = (cnt_q == 2'd2);
  assign status_o.count  = cnt_q;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i  ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/muw_back.sv =====
// back end: expands each queued command into output bytes, one per cycle while the output is not stalled
module muw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_v_i,
  input  muw_pkg::cmd_t     head_i,
  input  logic [7:0]        quote_char_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output muw_pkg::out_item_t out_data_o
);
  import muw_pkg::*;

  ph_e             ph_q, ph_d;
  logic [QD_W-1:0] qidx_q, qidx_d;
  logic            ov_q, ov_d;
  out_item_t       od_q, od_d;

  logic emit;
  logic sel_pre;
  logic sel_quote;

  assign emit = head_v_i && (!ov_q || out_ready_i);

  // output selection
  always_comb begin
    sel_pre   = (ph_q == PH_PRE) && head_i.pre_v;
    sel_quote = !sel_pre && (qidx_q < head_i.qcnt);
    pop_o     = emit && !sel_pre && !sel_quote;
    od_d      = od_q;
    if (emit) begin
      priority if (sel_pre) begin
        od_d.char_out    = head_i.pre_c;
        od_d.last_of_run = 1'b0;
      end else if (sel_quote) begin
        od_d.char_out    = quote_char_i;
        od_d.last_of_run = 1'b0;
      end else begin
        od_d.char_out    = head_i.main_c;
        od_d.last_of_run = 1'b1;
      end
    end
    ov_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  // phase sequencing
  always_comb begin
    ph_d   = ph_q;
    qidx_d = qidx_q;
    if (emit) begin
      priority if (sel_pre) begin
        ph_d = PH_QUOTE;
      end else if (sel_quote) begin
        ph_d   = PH_QUOTE;
        qidx_d = qidx_q + QD_W'(1);
      end else begin
        ph_d   = PH_PRE;
        qidx_d = '0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_PRE;
      qidx_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      qidx_q <= qidx_d;
      ov_q   <= ov_d;
    end
  end

endmodule

// ===== rtl/mail_text_unwrapper.sv =====
// top level of the mail text unwrapper: config registers, front, queue, back
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    char_in, end_of_text
//  out      out  out_valid/out_ready  char_out, last_of_run
//  cfg      in   cfg_valid/cfg_ready  cfg_index (3b), cfg_data (8b)
//
// the front takes one item per cycle while the two-entry command queue has room
// the back puts out one byte per cycle unless the output stalls, 1 to MaxQuoteDepth+2
// bytes per item, so the sustained rate is set by the output byte count of each item
// an item that produces no byte (space, quote marker) only updates line state
// reset is asynchronous and restores line state and register defaults
// a stalled output holds its byte; the queue lets the front keep going until it fills
module mail_text_unwrapper #(
  parameter int unsigned MaxQuoteDepth = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  muw_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output muw_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [muw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);
  import muw_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      in_accept;
  logic      q_push;
  cmd_t      q_cmd;
  logic      q_pop;
  logic      head_v;
  cmd_t      head;
  q_status_t q_st;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_st.full;
  assign in_accept   = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_QUOTE_CHAR:  cfg_d.quote_char       = cfg_data_i;
        CFG_TAB_FOR_GAP: cfg_d.tab_for_gaps     = cfg_data_i[0];
        CFG_INDENT_LIM:  cfg_d.indent_limit     = cfg_data_i;
        CFG_SHORT_LIM:   cfg_d.short_line_limit = cfg_data_i;
        CFG_GAP_LIM:     cfg_d.gap_limit        = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quote_char       <= 8'd62;
      cfg_q.tab_for_gaps     <= 1'b1;
      cfg_q.indent_limit     <= 8'd20;
      cfg_q.short_line_limit <= 8'd40;
      cfg_q.gap_limit        <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  muw_front #(
    .MaxQuoteDepth(MaxQuoteDepth)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .item_i  (in_data_i),
    .cfg_i   (cfg_q),
    .push_o  (q_push),
    .cmd_o   (q_cmd)
  );

  muw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .pop_i   (q_pop),
    .head_v_o(head_v),
    .head_o  (head),
    .status_o(q_st)
  );

  muw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_v_i    (head_v),
    .head_i      (head),
    .quote_char_i(cfg_q.quote_char),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // queue never holds more than two commands
  a_q_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_st.count != 2'd3)
    else $error("command queue count out of range");

  // no push lands on a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_st.full))
    else $error("push into full command queue");

  // retiring a command always shows its final byte next cycle
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (out_valid_o && out_data_o.last_of_run))
    else $error("command retired without its final byte");

  // an empty queue means nothing new can be emitted
  a_idle_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_st.count == 2'd0) |-> !q_pop)
    else $error("pop from empty command queue");

endmodule
